@@ rtl/qdv_pkg.sv @@
package qdv_pkg;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int MUL_BITS = 36;
  localparam int PROD_W   = 84;
  localparam int MAG_W    = 48;
  localparam int DIV_W    = 34;

  localparam logic [MUL_BITS-1:0] RATE_K     = 36'd65536000000;
  localparam logic [MUL_BITS-1:0] TWO_PI_Q32 = 36'd26986075409;
  localparam logic [MAG_W-1:0]    RATE_CAP   = 48'h7FFF_FFFF_FFFF;
  localparam logic [MAG_W-1:0]    Q16_CAP    = 48'h0000_8000_0000;
  localparam logic [31:0]         TS_MAX     = 32'd500000;
  localparam logic [31:0]         TS_DEFAULT = 32'd1000;
  localparam logic [31:0]         TH_STALE   = 32'd100000;

  localparam logic [1:0] CMD_EDGE_A = 2'd0;
  localparam logic [1:0] CMD_EDGE_B = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    K_EDGE_A,
    K_EDGE_B,
    K_SAMPLE,
    K_NONE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        level;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic                 full;
    logic [QPTR_W:0]      fill;
  } q_status_t;

  typedef enum logic [1:0] {
    SH_0,
    SH_16,
    SH_32
  } shift_t;

  typedef struct packed {
    logic [MAG_W-1:0]    a;
    logic [MUL_BITS-1:0] b;
    shift_t              shift;
    logic [DIV_W-1:0]    d;
    logic [MAG_W-1:0]    cap;
  } md_req_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [MAG_W-1:0] mag);
    logic [31:0] r;
    if (neg) begin
      r = (mag >= 48'h0000_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/qdv_front.sv @@
module qdv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic             in_level,
  input  logic [31:0]      in_now,
  output logic             q_valid,
  input  logic             q_ready,
  output qdv_pkg::item_t   q_item,
  output qdv_pkg::q_status_t status
);
  import qdv_pkg::*;

  item_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  item_t            cls;
  logic             push;
  logic             pop;

  always_comb begin
    case (in_cmd)
      CMD_EDGE_A: cls.kind = K_EDGE_A;
      CMD_EDGE_B: cls.kind = K_EDGE_B;
      CMD_SAMPLE: cls.kind = K_SAMPLE;
      default:    cls.kind = K_NONE;
    endcase
    cls.level  = in_level;
    cls.now_us = in_now;
  end

  assign in_ready = (fill != QPTR_W'(0) + (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign status.full = !in_ready;
  assign status.fill = fill;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      fill <= fill + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

@@ rtl/qdv_muldiv.sv @@
module qdv_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  qdv_pkg::md_req_t  req,
  output logic              done,
  output logic [47:0]       result
);
  import qdv_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV} mstate_t;

  localparam int CNT_W = $clog2(PROD_W);

  mstate_t             state;
  logic [PROD_W-1:0]   acc;
  logic [PROD_W-1:0]   ash;
  logic [MUL_BITS-1:0] bsh;
  logic [PROD_W-1:0]   num;
  logic [DIV_W-1:0]    rem;
  logic [MAG_W-1:0]    q;
  logic                ovf;
  logic [CNT_W-1:0]    cnt;
  shift_t              shift;
  logic [DIV_W-1:0]    d;
  logic [MAG_W-1:0]    cap;

  logic [PROD_W-1:0]   acc_next;
  logic [PROD_W-1:0]   num_next;
  logic [DIV_W:0]      r2;
  logic                ge;
  logic [DIV_W-1:0]    rem_next;
  logic [MAG_W-1:0]    q_next;
  logic                ovf_next;

  always_comb begin
    acc_next = bsh[0] ? acc + ash : acc;
    case (shift)
      SH_16:   num_next = acc_next >> 16;
      SH_32:   num_next = acc_next >> 32;
      default: num_next = acc_next;
    endcase
    r2       = {rem, num[PROD_W-1]};
    ge       = (r2 >= {1'b0, d});
    rem_next = ge ? DIV_W'(r2 - {1'b0, d}) : r2[DIV_W-1:0];
    q_next   = {q[MAG_W-2:0], ge};
    ovf_next = ovf | q[MAG_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            acc   <= '0;
            ash   <= PROD_W'(req.a);
            bsh   <= req.b;
            shift <= req.shift;
            d     <= req.d;
            cap   <= req.cap;
            cnt   <= '0;
            state <= M_MUL;
          end
        end
        M_MUL: begin
          acc <= acc_next;
          ash <= ash << 1;
          bsh <= bsh >> 1;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(MUL_BITS - 1)) begin
            num   <= num_next;
            rem   <= '0;
            q     <= '0;
            ovf   <= 1'b0;
            cnt   <= '0;
            state <= M_DIV;
          end
        end
        M_DIV: begin
          num <= num << 1;
          rem <= rem_next;
          q   <= q_next;
          ovf <= ovf_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(PROD_W - 1)) begin
            result <= (ovf_next || q_next > cap) ? cap : q_next;
            done   <= 1'b1;
            state  <= M_IDLE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/qdv_back.sv @@
module qdv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [15:0]      cfg_value,
  input  logic             q_valid,
  output logic             q_ready,
  input  qdv_pkg::item_t   q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      position_count,
  output logic [31:0]      angle_q16,
  output logic [31:0]      velocity_q16
);
  import qdv_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SMP, S_RATE_WAIT, S_VEL_GO, S_VEL_WAIT, S_ANG_GO, S_ANG_WAIT, S_OUT
  } state_t;

  state_t      state;
  logic [15:0] ticks_per_rev;
  logic [31:0] pulse_count;
  logic        level_a;
  logic        level_b;
  logic [31:0] last_edge_us;
  logic [31:0] prev_sample_us;
  logic [31:0] prev_since_edge_us;
  logic [31:0] prev_sample_count;
  logic [47:0] pulse_rate;
  logic [31:0] velocity_held;
  logic [31:0] angle;
  logic [31:0] sample_now;
  logic        rate_neg;
  logic        md_start;
  md_req_t     md_req;
  logic        md_done;
  logic [47:0] md_result;

  logic [17:0] cpr;
  logic [31:0] ts_raw;
  logic [31:0] ts;
  logic [31:0] th;
  logic [31:0] dn;
  logic        dn_neg;
  logic [31:0] dn_mag;
  logic [32:0] pos;
  logic [32:0] dtv;
  logic        rate_ok;
  logic        pr_neg;
  logic [47:0] pr_mag;
  logic        c_neg;
  logic [31:0] c_mag;

  qdv_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  always_comb begin
    cpr     = {(ticks_per_rev == 16'd0) ? 16'd1 : ticks_per_rev, 2'b00};
    ts_raw  = sample_now - prev_sample_us;
    ts      = (ts_raw == 32'd0 || ts_raw > TS_MAX) ? TS_DEFAULT : ts_raw;
    th      = sample_now - last_edge_us;
    dn      = pulse_count - prev_sample_count;
    dn_neg  = dn[31];
    dn_mag  = dn_neg ? (~dn + 32'd1) : dn;
    pos     = {1'b0, ts} + {1'b0, prev_since_edge_us};
    dtv     = pos - {1'b0, th};
    rate_ok = (dn_mag != 32'd0) && (pos > {1'b0, th}) && ({dtv, 1'b0} > {2'b00, ts});
    pr_neg  = pulse_rate[47];
    pr_mag  = pr_neg ? (~pulse_rate + 48'd1) : pulse_rate;
    c_neg   = pulse_count[31];
    c_mag   = c_neg ? (~pulse_count + 32'd1) : pulse_count;
  end

  assign q_ready        = (state == S_IDLE);
  assign position_count = pulse_count;
  assign angle_q16      = angle;
  assign velocity_q16   = velocity_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      ticks_per_rev      <= 16'd1;
      pulse_count        <= '0;
      level_a            <= 1'b0;
      level_b            <= 1'b0;
      last_edge_us       <= '0;
      prev_sample_us     <= '0;
      prev_since_edge_us <= '0;
      prev_sample_count  <= '0;
      pulse_rate         <= '0;
      velocity_held      <= '0;
      out_valid          <= 1'b0;
      md_start           <= 1'b0;
    end else begin
      md_start <= 1'b0;
      if (cfg_write) ticks_per_rev <= cfg_value;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              K_EDGE_A: begin
                pulse_count  <= pulse_count + ((level_a == level_b) ? 32'd1 : '1);
                level_a      <= q_item.level;
                last_edge_us <= q_item.now_us;
                state        <= S_ANG_GO;
              end
              K_EDGE_B: begin
                pulse_count  <= pulse_count + ((level_a != level_b) ? 32'd1 : '1);
                level_b      <= q_item.level;
                last_edge_us <= q_item.now_us;
                state        <= S_ANG_GO;
              end
              K_SAMPLE: begin
                sample_now <= q_item.now_us;
                state      <= S_SMP;
              end
              default: state <= S_ANG_GO;
            endcase
          end
        end
        S_SMP: begin
          prev_sample_us     <= sample_now;
          prev_since_edge_us <= th;
          prev_sample_count  <= pulse_count;
          rate_neg           <= dn_neg;
          if (th > TH_STALE) begin
            pulse_rate <= '0;
            state      <= S_VEL_GO;
          end else if (rate_ok) begin
            md_req.a     <= MAG_W'(dn_mag);
            md_req.b     <= RATE_K;
            md_req.shift <= SH_0;
            md_req.d     <= DIV_W'(dtv);
            md_req.cap   <= RATE_CAP;
            md_start     <= 1'b1;
            state        <= S_RATE_WAIT;
          end else begin
            state <= S_VEL_GO;
          end
        end
        S_RATE_WAIT: begin
          if (md_done) begin
            pulse_rate <= rate_neg ? (~md_result + 48'd1) : md_result;
            state      <= S_VEL_GO;
          end
        end
        S_VEL_GO: begin
          md_req.a     <= pr_mag;
          md_req.b     <= TWO_PI_Q32;
          md_req.shift <= SH_32;
          md_req.d     <= DIV_W'(cpr);
          md_req.cap   <= Q16_CAP;
          md_start     <= 1'b1;
          state        <= S_VEL_WAIT;
        end
        S_VEL_WAIT: begin
          if (md_done) begin
            velocity_held <= sat32(pr_neg, md_result);
            state         <= S_ANG_GO;
          end
        end
        S_ANG_GO: begin
          md_req.a     <= MAG_W'(c_mag);
          md_req.b     <= TWO_PI_Q32;
          md_req.shift <= SH_16;
          md_req.d     <= DIV_W'(cpr);
          md_req.cap   <= Q16_CAP;
          md_start     <= 1'b1;
          state        <= S_ANG_WAIT;
        end
        S_ANG_WAIT: begin
          if (md_done) begin
            angle     <= sat32(c_neg, md_result);
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/quadrature_decoder_velocity.sv @@
// Quadrature decoder with velocity estimate. Each request (edge on A, edge on B,
// velocity sample) yields one result carrying the count, the angle and the held
// velocity. Requests enter a four-deep queue; the back end serves one at a time
// through a shared bit-serial multiply-divide unit; each use runs 36 multiply
// steps and 84 divide steps between start and finish. An edge or an unused
// command needs one use, a sample up to three.
module quadrature_decoder_velocity (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // level[0], now_us[32:1], zero pad
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata    // position_count[31:0], angle_q16[63:32],
                                      // velocity_q16[95:64]
);
  import qdv_pkg::*;

  logic      q_valid;
  logic      q_ready;
  item_t     q_item;
  q_status_t q_status;
  logic [31:0] pos_c;
  logic [31:0] ang;
  logic [31:0] vel;

  assign cfg_ready = 1'b1;

  qdv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_level (s_axis_tdata[0]),
    .in_now   (s_axis_tdata[32:1]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .status   (q_status)
  );

  qdv_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_value      (cfg_data),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .position_count (pos_c),
    .angle_q16      (ang),
    .velocity_q16   (vel)
  );

  assign m_axis_tdata = {vel, ang, pos_c};

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    q_status.fill <= (QPTR_W+1)'(QDEPTH))
    else $error("queue fill above depth");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> q_status.full && q_valid)
    else $error("input stalled with room in queue");

  a_no_pop_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !q_ready)
    else $error("queue popped while result waits");

endmodule
